FILE: hdl/vrfb_pkg.sv
package vrfb_pkg;

    localparam int LANES  = 8;
    localparam int LANE_W = 16;
    localparam int BYTE_W = 8;

    typedef logic [LANES-1:0][LANE_W-1:0] row_t;

    typedef enum logic [2:0] {
        REQ_SEL_READ   = 3'd0,
        REQ_LANE_WRITE = 3'd1,
        REQ_BYTE_READ  = 3'd2,
        REQ_BYTE_WRITE = 3'd3,
        REQ_CTRL_READ  = 3'd4,
        REQ_CTRL_WRITE = 3'd5
    } req_type_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    localparam logic [4:0] CSR_CARRY   = 5'd0;
    localparam logic [4:0] CSR_COMPARE = 5'd1;
    localparam logic [4:0] CSR_EXTRA   = 5'd2;

    localparam logic [15:0] BYTE_MASK_LO = 16'h00FF;
    localparam logic [15:0] BYTE_MASK_HI = 16'hFF00;
    localparam logic [3:0]  SEL_FIXED    = 4'h8;
    localparam logic [3:0]  SEL_QUAD     = 4'h4;
    localparam logic [3:0]  SEL_PAIR     = 4'h2;
    localparam logic [2:0]  QUAD_KEEP    = 3'h4;
    localparam logic [2:0]  PAIR_KEEP    = 3'h6;

    typedef struct packed {
        logic [15:0] write_value;
        logic [3:0]  select_code;
        logic [2:0]  lane;
        logic [3:0]  element;
        logic [4:0]  reg_index;
        logic [2:0]  req_type;
    } req_t;

    typedef struct packed {
        logic        wr_en;
        logic [4:0]  index;
        logic [15:0] wdata;
    } csr_req_t;

    typedef struct packed {
        logic [15:0] rdata;
        logic        bad;
    } csr_rsp_t;

    function automatic logic [2:0] pick_lane(input logic [2:0] cur, input logic [3:0] sel);
        logic [2:0] r;
        priority if ((sel & SEL_FIXED) != 4'h0)
        begin
            r = sel[2:0];
        end
        else if ((sel & SEL_QUAD) != 4'h0)
        begin
            r = (cur & QUAD_KEEP) | {1'b0, sel[1:0]};
        end
        else if ((sel & SEL_PAIR) != 4'h0)
        begin
            r = (cur & PAIR_KEEP) | {2'b00, sel[0]};
        end
        else
        begin
            r = cur;
        end
        return r;
    endfunction

endpackage

FILE: hdl/vrfb_row_mem.sv
module vrfb_row_mem #(
    parameter int NUM_REGS = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 rd_en,
    input  logic [$clog2(NUM_REGS)-1:0]          rd_addr,
    input  logic                                 wr_en,
    input  logic [$clog2(NUM_REGS)-1:0]          wr_addr,
    input  vrfb_pkg::row_t                       wr_data,
    output vrfb_pkg::row_t                       rd_row
);
    import vrfb_pkg::*;

    row_t                mem [NUM_REGS];
    row_t                rd_data_reg;
    logic                rd_valid_reg;
    logic [NUM_REGS-1:0] row_valid_reg;

    // A row never written since reset reads as zero.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                row_valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= row_valid_reg[rd_addr];
            end
        end
    end

    assign rd_row = rd_valid_reg ? rd_data_reg : '0;

endmodule

FILE: hdl/vrfb_csr.sv
module vrfb_csr (
    input  logic               clk,
    input  logic               rst_n,
    input  vrfb_pkg::csr_req_t req,
    output vrfb_pkg::csr_rsp_t rsp
);
    import vrfb_pkg::*;

    logic [15:0]       carry_reg;
    logic [15:0]       compare_reg;
    logic [BYTE_W-1:0] extra_reg;

    always_comb
    begin
        rsp = '0;
        unique case (req.index)
            CSR_CARRY:   rsp.rdata = carry_reg;
            CSR_COMPARE: rsp.rdata = compare_reg;
            CSR_EXTRA:   rsp.rdata = {8'h00, extra_reg};
            default:     rsp.bad   = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carry_reg   <= '0;
            compare_reg <= '0;
            extra_reg   <= '0;
        end
        else if (req.wr_en)
        begin
            unique case (req.index)
                CSR_CARRY:   carry_reg   <= req.wdata;
                CSR_COMPARE: compare_reg <= req.wdata;
                CSR_EXTRA:   extra_reg   <= req.wdata[BYTE_W-1:0];
                default:     ;
            endcase
        end
    end

endmodule

FILE: hdl/vector_register_file_broadcast.sv
// Channel  Direction  Payload
// s_*      in         request: req_type, reg_index, element, lane, select_code, write_value
// m_*      out        result: read_data, bad_index
//
// Each request reads the addressed register row from the row memory (separate read
// and write ports) on acceptance, then merges and writes the row back and loads the result.
// A new request is accepted while the previous result waits in the output register.
// A stalled output holds the block in ST_EXEC until the result is taken.
// Reset is asynchronous; no clearing pass runs, rows read as zero until first written.
module vector_register_file_broadcast #(
    parameter int NUM_REGS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // req_type[2:0], reg_index[7:3], element[11:8], lane[14:12],
    // select_code[18:15], write_value[34:19], zero fill above.
    input  logic [39:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // read_data[15:0], bad_index[16], zero fill above.
    output logic [23:0] m_tdata
);
    import vrfb_pkg::*;

    localparam int ADDR_W = $clog2(NUM_REGS);

    state_t      state_reg;
    state_t      state_next;
    req_t        req_reg;
    logic        out_valid_reg;
    logic [15:0] out_data_reg;
    logic        out_bad_reg;

    logic        accept;
    logic        finish;
    logic        in_range;
    logic [5:0]  reg_ext;
    logic [5:0]  in_reg_ext;
    row_t        row;
    row_t        row_new;
    logic [15:0] lane_val;
    logic [15:0] byte_lane_val;
    logic [15:0] out_data_next;
    logic        out_bad_next;
    logic        mem_wr_en;
    req_type_t   rtype;
    csr_req_t    csr_req;
    csr_rsp_t    csr_rsp;

    assign accept     = s_tvalid && s_tready;
    assign rtype      = req_type_t'(req_reg.req_type);
    assign reg_ext    = {1'b0, req_reg.reg_index};
    assign in_reg_ext = {1'b0, s_tdata[7:3]};
    assign in_range   = {2'b00, req_reg.reg_index} < 7'(NUM_REGS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        finish     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    finish     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req_t'(s_tdata[34:0]);
        end
    end

    vrfb_row_mem #(
        .NUM_REGS (NUM_REGS)
    ) u_row_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (in_reg_ext[ADDR_W-1:0]),
        .wr_en   (mem_wr_en),
        .wr_addr (reg_ext[ADDR_W-1:0]),
        .wr_data (row_new),
        .rd_row  (row)
    );

    assign csr_req.wr_en = finish && (rtype == REQ_CTRL_WRITE);
    assign csr_req.index = req_reg.reg_index;
    assign csr_req.wdata = req_reg.write_value;

    vrfb_csr u_csr (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (csr_req),
        .rsp   (csr_rsp)
    );

    assign lane_val      = row[pick_lane(req_reg.lane, req_reg.select_code)];
    assign byte_lane_val = row[req_reg.element[3:1]];

    always_comb
    begin
        row_new       = row;
        out_data_next = '0;
        out_bad_next  = 1'b0;
        mem_wr_en     = 1'b0;
        unique case (rtype)
            REQ_SEL_READ:
            begin
                out_data_next = in_range ? lane_val : '0;
            end
            REQ_LANE_WRITE:
            begin
                row_new[req_reg.element[2:0]] = req_reg.write_value;
                mem_wr_en = finish && in_range;
            end
            REQ_BYTE_READ:
            begin
                if (in_range)
                begin
                    out_data_next = req_reg.element[0]
                        ? (byte_lane_val & BYTE_MASK_LO)
                        : ((byte_lane_val & BYTE_MASK_HI) >> BYTE_W);
                end
            end
            REQ_BYTE_WRITE:
            begin
                row_new[req_reg.element[3:1]] = req_reg.element[0]
                    ? ((byte_lane_val & BYTE_MASK_HI) | (req_reg.write_value & BYTE_MASK_LO))
                    : ((byte_lane_val & BYTE_MASK_LO)
                       | ((req_reg.write_value & BYTE_MASK_LO) << BYTE_W));
                mem_wr_en = finish && in_range;
            end
            REQ_CTRL_READ:
            begin
                out_data_next = csr_rsp.rdata;
                out_bad_next  = csr_rsp.bad;
            end
            REQ_CTRL_WRITE:
            begin
                out_bad_next = csr_rsp.bad;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            out_data_reg <= out_data_next;
            out_bad_reg  <= out_bad_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_bad_reg, out_data_reg};

    a_load_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == ST_EXEC))
        else $error("result appeared without an executing request");

    a_stall_holds_exec: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EXEC && out_valid_reg && !m_tready |=> state_reg == ST_EXEC)
        else $error("request finished while the output was stalled");

    a_bad_only_ctrl: assert property (@(posedge clk) disable iff (!rst_n)
        finish && out_bad_next |-> rtype == REQ_CTRL_READ || rtype == REQ_CTRL_WRITE)
        else $error("error flag raised for a non-control request");

    a_writes_zero: assert property (@(posedge clk) disable iff (!rst_n)
        finish && (rtype == REQ_LANE_WRITE || rtype == REQ_BYTE_WRITE
                   || rtype == REQ_CTRL_WRITE) |=> m_tdata[15:0] == 16'h0000)
        else $error("write returned nonzero data");

endmodule
